>>> rtl/bilinear_image_sampler_top_assert.svh
// Assertion macros for the bilinear image sampler checker.
`ifndef BILINEAR_IMAGE_SAMPLER_TOP_ASSERT_SVH
`define BILINEAR_IMAGE_SAMPLER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BIS_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// Implication whose consequent is checked in the following cycle.
`define BIS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

>>> rtl/bis_pkg.sv
// Shared types and constants for the bilinear image sampler.
package bis_pkg;
    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 256;
    localparam int FRAC_BITS = 15;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int SIZE_W    = 9;
    localparam int WGT_W     = FRAC_BITS + 1;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;      // capture the input word and run the setup math
        logic       mem_we;    // write the captured pixel
        logic       mem_rd;    // read the pixel at the selected tap
        logic [1:0] tap;       // 0: (x,y) 1: (x+1,y) 2: (x,y+1) 3: (x+1,y+1)
        logic       acc_clr;   // clear accumulators and take tap 0 product
        logic       acc_en;    // add the product of the returned pixel
        logic       finish;    // form the result word
    } bis_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       in_range;  // column and row inside the configured size
        logic       in_square; // sample coordinates inside the unit square
        logic       edge_hit;  // sample on the last column or row
    } bis_stat_t;
endpackage

>>> rtl/bis_ctrl.sv
// Sequencer for the bilinear image sampler.
module bis_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  bis_pkg::bis_stat_t  stat,
    output bis_pkg::bis_cmd_t   cmd
);
    import bis_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cnt_next = 3'd0;
                if (stat.op == OP_WRITE)
                begin
                    cmd.mem_we = stat.in_range;
                    state_next = S_DONE;
                end
                else if (stat.op == OP_READ && stat.in_range)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_RD;
                end
                else if (stat.op == OP_SAMPLE && stat.in_square)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.tap    = 2'd0;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                // cnt_reg counts pixels already added to the accumulators.
                cmd.acc_en  = (cnt_reg != 3'd0);
                cmd.acc_clr = (cnt_reg == 3'd0);
                if (stat.op == OP_SAMPLE && !stat.edge_hit && cnt_reg < 3'd3)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.tap    = cnt_reg[1:0] + 2'd1;
                    cnt_next   = cnt_reg + 3'd1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_next)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

>>> rtl/bis_datapath.sv
// Pixel store, coordinate math and weighted accumulation.
module bis_datapath (
    input  logic                clk,
    input  bis_pkg::bis_cmd_t   cmd,
    output bis_pkg::bis_stat_t  stat,
    input  logic [8:0]          width_in_use,
    input  logic [8:0]          height_in_use,
    input  logic [1:0]          operation,
    input  logic [7:0]          col,
    input  logic [7:0]          row,
    input  logic [7:0]          red_in,
    input  logic [7:0]          green_in,
    input  logic [7:0]          blue_in,
    input  logic signed [15:0]  norm_x,
    input  logic signed [15:0]  norm_y,
    output logic                status,
    output logic [7:0]          red_out,
    output logic [7:0]          green_out,
    output logic [7:0]          blue_out
);
    import bis_pkg::*;

    localparam int ACC_W = 8 + 2 * FRAC_BITS + 2;
    localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

    logic [23:0] mem [0:MAX_COLS*MAX_ROWS-1];
    logic [23:0] rdata_reg;

    logic [1:0]        op_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [23:0]       wpix_reg;
    logic              in_range_reg, inside_reg;
    logic [COL_W-1:0]  x_reg;
    logic [ROW_W-1:0]  y_reg;
    logic              edge_reg;
    logic [WGT_W-1:0]  dx_reg, dy_reg;
    logic [ACC_W-1:0]  acc_reg [0:2];
    logic [2*WGT_W-1:0] wgt_reg;

    logic [SIZE_W-1:0] w_eff, h_eff;
    logic signed [16:0] sx, sy;
    logic [15+SIZE_W-1:0] px, py;
    logic [COL_W:0] xi;
    logic [ROW_W:0] yi;

    always_comb
    begin
        w_eff = (width_in_use == '0) ? SIZE_W'(1) :
                (width_in_use > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : width_in_use;
        h_eff = (height_in_use == '0) ? SIZE_W'(1) :
                (height_in_use > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : height_in_use;
        sx = 17'(norm_x) + 17'sd16384;
        sy = 17'sd16384 - 17'(norm_y);
        px = 15'(sx) * (w_eff - SIZE_W'(1));
        py = 15'(sy) * (h_eff - SIZE_W'(1));
        xi = (COL_W+1)'(px >> 15);
        yi = (ROW_W+1)'(py >> 15);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= operation;
            col_reg      <= COL_W'(col);
            row_reg      <= ROW_W'(row);
            wpix_reg     <= {red_in, green_in, blue_in};
            in_range_reg <= ({1'b0, col} < w_eff) && ({1'b0, row} < h_eff);
            inside_reg   <= (sx >= 0) && (sx < 17'sd32768) && (sy >= 0) && (sy < 17'sd32768);
            x_reg        <= COL_W'(xi);
            y_reg        <= ROW_W'(yi);
            edge_reg     <= ((SIZE_W)'(xi) == w_eff - SIZE_W'(1)) ||
                            ((SIZE_W)'(yi) == h_eff - SIZE_W'(1));
            dx_reg       <= WGT_W'({px[14:0], {FRAC_BITS{1'b0}}} >> 15);
            dy_reg       <= WGT_W'({py[14:0], {FRAC_BITS{1'b0}}} >> 15);
        end
    end

    assign stat.op        = op_reg;
    assign stat.in_range  = in_range_reg;
    assign stat.in_square = inside_reg;
    assign stat.edge_hit  = edge_reg;

    // Single-port pixel store; one access per cycle.
    logic [COL_W-1:0] ax;
    logic [ROW_W-1:0] ay;
    always_comb
    begin
        if (op_reg == OP_SAMPLE)
        begin
            ax = x_reg + COL_W'(cmd.tap[0]);
            ay = y_reg + ROW_W'(cmd.tap[1]);
        end
        else
        begin
            ax = col_reg;
            ay = row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[{ay, ax}] <= wpix_reg;
        else if (cmd.mem_rd)
            rdata_reg <= mem[{ay, ax}];
    end

    // Weight for the tap being read is registered alongside the read data.
    logic [WGT_W-1:0] wa, wb;
    always_comb
    begin
        wa = cmd.tap[0] ? dx_reg : ONE - dx_reg;
        wb = cmd.tap[1] ? dy_reg : ONE - dy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            wgt_reg <= wa * wb;
        end
    end

    logic [ACC_W-1:0] prod [0:2];
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            prod[c] = ACC_W'(rdata_reg[16-8*c +: 8]) * ACC_W'(wgt_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (cmd.acc_clr)
                acc_reg[c] <= prod[c];
            else if (cmd.acc_en)
                acc_reg[c] <= acc_reg[c] + prod[c];
        end
    end

    logic [ACC_W-1:0] acc_last [0:2];
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status <= (op_reg == OP_WRITE || op_reg == OP_READ) && !in_range_reg;
            if (op_reg == OP_READ && in_range_reg)
                {red_out, green_out, blue_out} <= rdata_reg;
            else if (op_reg == OP_SAMPLE && inside_reg && edge_reg)
                {red_out, green_out, blue_out} <= rdata_reg;
            else if (op_reg == OP_SAMPLE && inside_reg)
            begin
                red_out   <= (acc_last[0] >> (2*FRAC_BITS)) > 255 ? 8'hFF :
                             8'(acc_last[0] >> (2*FRAC_BITS));
                green_out <= (acc_last[1] >> (2*FRAC_BITS)) > 255 ? 8'hFF :
                             8'(acc_last[1] >> (2*FRAC_BITS));
                blue_out  <= (acc_last[2] >> (2*FRAC_BITS)) > 255 ? 8'hFF :
                             8'(acc_last[2] >> (2*FRAC_BITS));
            end
            else
                {red_out, green_out, blue_out} <= 24'd0;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            acc_last[c] = acc_reg[c];
    end
endmodule

>>> rtl/bilinear_image_sampler_top.sv
// Sequence: a write, an out-of-range read, an off-image sample or the unused code
// goes from decode straight to done; a read or an edge sample passes through the
// read state once, and an interpolated sample stays there while it reads four taps
// from the single-port pixel store. Input is taken only while the sequencer is idle,
// and a stalled result holds back the finish of the next word.
// Reset: asynchronous, active low; both sizes return to 256, pixel store undefined.
module bilinear_image_sampler_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [7:0]         col,
    input  logic [7:0]         row,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out
);
    import bis_pkg::*;

    // Configuration registers: width at byte 0, height at byte 4.
    logic [8:0] width_reg, height_reg;
    logic       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_WIDTH)
                width_reg <= pwdata[8:0];
            else
                height_reg <= pwdata[8:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_WIDTH)
            prdata = {23'd0, width_reg};
        else
            prdata = {23'd0, height_reg};
    end

    // The controller sequences memory taps; the datapath does the coordinate and pixel arithmetic.
    bis_cmd_t  cmd;
    bis_stat_t stat;

    bis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bis_datapath u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .stat          (stat),
        .width_in_use  (width_reg),
        .height_in_use (height_reg),
        .operation     (operation),
        .col           (col),
        .row           (row),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .norm_x        (norm_x),
        .norm_y        (norm_y),
        .status        (status),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out)
    );
endmodule

>>> rtl/bis_checker.sv
// Port-level checker for the bilinear image sampler, bound to the top level.
`include "bilinear_image_sampler_top_assert.svh"
module bis_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       status,
    input logic [7:0] red_out,
    input logic       pready
);
    `BIS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accept not followed by busy")
    `BIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(red_out), "stalled result changed")
    `BIS_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, pready, "pready low")
    `BIS_ASSERT_NEXT(a_no_new_result_idle, clk, rst_n, !out_valid && !in_stall, !out_valid, "result without word")
endmodule

bind bilinear_image_sampler_top bis_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .red_out   (red_out),
    .pready    (pready)
);

>>> bench/bilinear_image_sampler_top_tb.sv
// Self-checking testbench for the bilinear image sampler: pixel writes, reads and samples.
module bilinear_image_sampler_top_tb;
    import bis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 12;

    // One result word as the block hands it out.
    typedef struct packed {
        logic       status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         operation = '0;
    logic [7:0]         col = '0;
    logic [7:0]         row = '0;
    logic [7:0]         red_in = '0;
    logic [7:0]         green_in = '0;
    logic [7:0]         blue_in = '0;
    logic signed [15:0] norm_x = '0;
    logic signed [15:0] norm_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               status;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;

    bilinear_image_sampler_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .col       (col),
        .row       (row),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    always #4 clk = ~clk;

    // Our own copy of the image and of the size registers, as the block should hold them.
    logic [23:0]  image_mem [MAX_COLS*MAX_ROWS];
    bit           image_written [MAX_COLS*MAX_ROWS];
    int           written_cells [$];
    logic [8:0]   width_reg = 9'd256;
    logic [8:0]   height_reg = 9'd256;

    // Result words predicted at acceptance, oldest first.
    pixel_word_t  pending_words [$];
    int           error_count = 0;
    int           cycle_count = 0;

    // Idle controls: quiet flags switch off random gaps, holdoff_request asks for a long stall.
    bit           sender_quiet = 1'b0;
    bit           receiver_quiet = 1'b0;
    int           holdoff_request = 0;
    int           holdoff_left = 0;
    int           stall_left = 0;

    function automatic int clamp_size(input logic [8:0] v, input int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic int cur_width();
        return clamp_size(width_reg, MAX_COLS);
    endfunction

    function automatic int cur_height();
        return clamp_size(height_reg, MAX_ROWS);
    endfunction

    function automatic logic [23:0] pixel_at(input int x, input int y);
        if (x < 0 || y < 0 || x >= MAX_COLS || y >= MAX_ROWS) return 24'd0;
        return image_mem[y*MAX_COLS + x];
    endfunction

    function automatic bit cell_written(input int x, input int y);
        if (x < 0 || y < 0 || x >= MAX_COLS || y >= MAX_ROWS) return 1'b0;
        return image_written[y*MAX_COLS + x];
    endfunction

    // Maps normalized coordinates onto the image grid: integer cell, fraction, and flags.
    function automatic void locate_sample(input logic signed [15:0] nx,
                                          input logic signed [15:0] ny,
                                          output bit in_square, output bit edge_hit,
                                          output int x, output int y,
                                          output longint dx, output longint dy);
        longint sx, sy, px, py;
        int     w, h;
        w = cur_width();
        h = cur_height();
        sx = longint'(nx) + 16384;
        sy = 16384 - longint'(ny);
        in_square = (sx >= 0 && sx < 32768 && sy >= 0 && sy < 32768);
        px = sx * (w - 1);
        py = sy * (h - 1);
        x = int'(px >>> 15);
        y = int'(py >>> 15);
        dx = ((px & 32767) << FRAC_BITS) >> 15;
        dy = ((py & 32767) << FRAC_BITS) >> 15;
        edge_hit = (x == w - 1) || (y == h - 1);
    endfunction

    // True when every pixel the sample would touch has been written.
    function automatic bit sample_cells_written(input logic signed [15:0] nx,
                                                input logic signed [15:0] ny);
        bit     in_square, edge_hit;
        int     x, y;
        longint dx, dy;
        locate_sample(nx, ny, in_square, edge_hit, x, y, dx, dy);
        if (!in_square) return 1'b1;
        if (edge_hit) return cell_written(x, y);
        return cell_written(x, y) && cell_written(x + 1, y) &&
               cell_written(x, y + 1) && cell_written(x + 1, y + 1);
    endfunction

    function automatic logic [23:0] blend_pixels(input int x, input int y,
                                                 input longint dx, input longint dy);
        longint      one, w00, w01, w10, w11, acc, v;
        logic [23:0] p00, p01, p10, p11, result;
        one = longint'(1) << FRAC_BITS;
        w00 = (one - dx) * (one - dy);
        w01 = dx * (one - dy);
        w10 = (one - dx) * dy;
        w11 = dx * dy;
        p00 = pixel_at(x, y);
        p01 = pixel_at(x + 1, y);
        p10 = pixel_at(x, y + 1);
        p11 = pixel_at(x + 1, y + 1);
        result = '0;
        for (int c = 0; c < 3; c++) begin
            acc = longint'(p00[16-8*c +: 8]) * w00 + longint'(p01[16-8*c +: 8]) * w01 +
                  longint'(p10[16-8*c +: 8]) * w10 + longint'(p11[16-8*c +: 8]) * w11;
            v = acc >> (2*FRAC_BITS);
            if (v > 255) v = 255;
            result[16-8*c +: 8] = v[7:0];
        end
        return result;
    endfunction

    // Computes the result word of one accepted input word and updates the image copy.
    function automatic pixel_word_t predict_pixel_word(input logic [1:0] op,
                                                       input logic [7:0] c, input logic [7:0] r,
                                                       input logic [23:0] rgb,
                                                       input logic signed [15:0] nx,
                                                       input logic signed [15:0] ny);
        pixel_word_t word;
        logic [23:0] pix;
        bit          in_square, edge_hit;
        int          x, y;
        longint      dx, dy;
        word = '0;
        pix = '0;
        if (op == OP_WRITE || op == OP_READ) begin
            if (c >= cur_width() || r >= cur_height()) begin
                word.status = 1'b1;
            end else if (op == OP_WRITE) begin
                image_mem[r*MAX_COLS + c] = rgb;
                if (!image_written[r*MAX_COLS + c]) written_cells.push_back(r*MAX_COLS + c);
                image_written[r*MAX_COLS + c] = 1'b1;
            end else begin
                pix = pixel_at(c, r);
            end
        end else if (op == OP_SAMPLE) begin
            locate_sample(nx, ny, in_square, edge_hit, x, y, dx, dy);
            if (in_square) pix = edge_hit ? pixel_at(x, y) : blend_pixels(x, y, dx, dy);
        end
        word.red = pix[23:16];
        word.green = pix[15:8];
        word.blue = pix[7:0];
        return word;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 65) return 0;
        if (k < 90) return $urandom_range(1, 3);
        if (k < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Offers one word and returns just after the edge that takes it (or after the gap).
    // Must be entered right after a rising edge.
    task automatic send_word(input logic [1:0] op, input logic [7:0] c, input logic [7:0] r,
                             input logic [23:0] rgb, input logic signed [15:0] nx,
                             input logic signed [15:0] ny);
        int gap;
        operation <= op;
        col <= c;
        row <= r;
        red_in <= rgb[23:16];
        green_in <= rgb[15:8];
        blue_in <= rgb[7:0];
        norm_x <= nx;
        norm_y <= ny;
        in_valid <= 1'b1;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        pending_words.push_back(predict_pixel_word(op, c, r, rgb, nx, ny));
        gap = sender_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every predicted word has come out, plus the block's longest latency.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup phase, access phase, then an idle pause with psel low before the next transfer.
    task automatic write_register(input logic [2:0] addr, input logic [8:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {23'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == {REG_HEIGHT, 2'b00}) height_reg = value;
        else width_reg = value;
        @(posedge clk);
    endtask

    task automatic set_image_size(input logic [8:0] w, input logic [8:0] h);
        wait_drained();
        write_register({REG_WIDTH, 2'b00}, w);
        write_register({REG_HEIGHT, 2'b00}, h);
    endtask

    // Writes every pixel of the configured area that has not been written yet.
    task automatic fill_image();
        for (int r = 0; r < cur_height(); r++)
            for (int c = 0; c < cur_width(); c++)
                if (!cell_written(c, r))
                    send_word(OP_WRITE, c[7:0], r[7:0], 24'($urandom()), 16'($urandom()),
                              16'($urandom()));
    endtask

    // Chooses sample coordinates whose touched pixels are all written; mostly near a
    // written pixel, sometimes anywhere in the 16-bit space.
    task automatic pick_sample_coords(output logic signed [15:0] nx,
                                      output logic signed [15:0] ny);
        int     w, h, cell_idx, cx, cy;
        longint sx, sy;
        w = cur_width();
        h = cur_height();
        for (int attempt = 0; attempt < 40; attempt++) begin
            if ($urandom_range(0, 9) == 0 || written_cells.size() == 0) begin
                nx = 16'($urandom());
                ny = 16'($urandom());
            end else begin
                cell_idx = written_cells[$urandom_range(0, written_cells.size() - 1)];
                cx = cell_idx % MAX_COLS;
                cy = cell_idx / MAX_COLS;
                sx = (w > 1) ? (longint'(cx) * 32768 + $urandom_range(0, 32767)) / (w - 1)
                             : $urandom_range(0, 32767);
                sy = (h > 1) ? (longint'(cy) * 32768 + $urandom_range(0, 32767)) / (h - 1)
                             : $urandom_range(0, 32767);
                if (sx > 32767) sx = 32767;
                if (sy > 32767) sy = 32767;
                // Now and then hit the very borders of the unit square.
                case ($urandom_range(0, 15))
                    0: sx = 0;
                    1: sx = 32767;
                    2: sy = 0;
                    3: sy = 32767;
                    default: ;
                endcase
                nx = 16'(sx - 16384);
                ny = 16'(16384 - sy);
            end
            if (sample_cells_written(nx, ny)) return;
        end
        // Falls back to a point left of the image, which always gives black.
        nx = 16'sh8000;
        ny = 16'($urandom());
    endtask

    // One random word: writes, reads of written pixels or out of range, samples, unused code.
    task automatic send_random_word();
        int               k, w, h;
        logic [1:0]       op;
        logic [7:0]       c, r;
        logic [23:0]      rgb;
        logic signed [15:0] nx, ny;
        bit               found;
        w = cur_width();
        h = cur_height();
        c = 8'($urandom());
        r = 8'($urandom());
        rgb = 24'($urandom());
        nx = 16'($urandom());
        ny = 16'($urandom());
        k = $urandom_range(0, 99);
        if (k < 25) begin
            op = OP_WRITE;
            if ($urandom_range(0, 9) != 0) begin
                c = 8'($urandom_range(0, w - 1));
                r = 8'($urandom_range(0, h - 1));
            end
        end else if (k < 45) begin
            op = OP_READ;
            found = 1'b0;
            for (int attempt = 0; attempt < 30 && !found; attempt++) begin
                if ($urandom_range(0, 7) != 0) begin
                    c = 8'($urandom_range(0, w - 1));
                    r = 8'($urandom_range(0, h - 1));
                end else begin
                    c = 8'($urandom());
                    r = 8'($urandom());
                end
                found = (c >= w || r >= h || cell_written(c, r));
            end
            if (!found) op = OP_WRITE;
        end else if (k < 92) begin
            op = OP_SAMPLE;
            pick_sample_coords(nx, ny);
        end else begin
            op = OP_UNUSED;
        end
        send_word(op, c, r, rgb, nx, ny);
    endtask

    // Default 256 x 256 image: channel extremes, corner taps, square borders, unused code.
    task automatic test_directed_extremes();
        send_word(OP_WRITE, 8'd0, 8'd0, 24'hFFFFFF, 16'sh7FFF, 16'sh8000);
        send_word(OP_WRITE, 8'd1, 8'd0, 24'h000000, 16'sh0000, 16'sh0000);
        send_word(OP_WRITE, 8'd0, 8'd1, 24'hFF00FF, 16'sh0000, 16'sh0000);
        send_word(OP_WRITE, 8'd1, 8'd1, 24'h00FF00, 16'sh0000, 16'sh0000);
        send_word(OP_WRITE, 8'd254, 8'd254, 24'h123456, 16'sh0000, 16'sh0000);
        send_word(OP_WRITE, 8'd255, 8'd254, 24'hFEDCBA, 16'sh0000, 16'sh0000);
        send_word(OP_WRITE, 8'd254, 8'd255, 24'h80FF01, 16'sh0000, 16'sh0000);
        send_word(OP_WRITE, 8'd255, 8'd255, 24'hFFFFFF, 16'sh0000, 16'sh0000);
        send_word(OP_READ, 8'd0, 8'd0, 24'h000000, 16'sh0000, 16'sh0000);
        send_word(OP_READ, 8'd255, 8'd255, 24'hFFFFFF, 16'sh0000, 16'sh0000);
        send_word(OP_READ, 8'd1, 8'd0, 24'hFFFFFF, 16'sh0000, 16'sh0000);
        // Top-left corner of the unit square, then the farthest point inside it.
        send_word(OP_SAMPLE, 8'hFF, 8'hFF, 24'hFFFFFF, -16'sd16384, 16'sd16384);
        send_word(OP_SAMPLE, 8'h00, 8'h00, 24'h000000, 16'sd16383, -16'sd16383);
        send_word(OP_SAMPLE, 8'h00, 8'h00, 24'h000000, -16'sd16300, 16'sd16300);
        // Points just outside each border, and the extreme codes, all give black.
        send_word(OP_SAMPLE, 8'h00, 8'h00, 24'h000000, 16'sd16384, 16'sd0);
        send_word(OP_SAMPLE, 8'h00, 8'h00, 24'h000000, -16'sd16385, 16'sd0);
        send_word(OP_SAMPLE, 8'h00, 8'h00, 24'h000000, 16'sd0, -16'sd16384);
        send_word(OP_SAMPLE, 8'h00, 8'h00, 24'h000000, 16'sd0, 16'sd16385);
        send_word(OP_SAMPLE, 8'h00, 8'h00, 24'h000000, 16'sh8000, 16'sh7FFF);
        send_word(OP_SAMPLE, 8'h00, 8'h00, 24'h000000, 16'sh7FFF, 16'sh8000);
        send_word(OP_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF, 16'shFFFF, 16'shFFFF);
        send_word(OP_UNUSED, 8'h00, 8'h00, 24'h000000, 16'sh0000, 16'sh0000);
    endtask

    // Walks through image sizes: single pixel, zero acting as one, thin strips, sizes
    // above the maximum acting as the maximum. Each image is filled, then exercised.
    task automatic test_size_sweep();
        logic [8:0] widths [10]  = '{9'd1, 9'd0, 9'd2, 9'd1, 9'd7, 9'd5, 9'd400, 9'd1,
                                     9'd6, 9'd3};
        logic [8:0] heights [10] = '{9'd1, 9'd0, 9'd2, 9'd7, 9'd1, 9'd3, 9'd1, 9'd511,
                                     9'd6, 9'd9};
        for (int p = 0; p < 10; p++) begin
            set_image_size(widths[p], heights[p]);
            sender_quiet = (p % 4 == 1);
            receiver_quiet = (p % 4 == 2);
            fill_image();
            repeat (40) send_random_word();
        end
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    // Back to the full 256 x 256 image with a written patch at rows 120 to 123, columns 60 to 71.
    task automatic test_full_image();
        set_image_size(9'd256, 9'd256);
        for (int r = 120; r < 124; r++)
            for (int c = 60; c < 72; c++)
                send_word(OP_WRITE, c[7:0], r[7:0], 24'($urandom()), 16'sh0000, 16'sh0000);
        repeat (60) send_random_word();
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the
    // block fills up and stalls its input.
    task automatic test_output_holdoff();
        set_image_size(9'd16, 9'd16);
        sender_quiet = 1'b1;
        holdoff_request = 300;
        repeat (40) send_random_word();
        sender_quiet = 1'b0;
    endtask

    // The sender stops until every result has come, then resumes.
    task automatic test_drain_pause();
        repeat (30) send_random_word();
        wait_drained();
        repeat (30) send_random_word();
    endtask

    // Receiver stall: a requested long hold-off first, else random gaps or quiet stretches.
    always @(posedge clk) begin
        if (holdoff_request != 0) begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left > 0) begin
            out_stall <= 1'b1;
            holdoff_left--;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (receiver_quiet || $urandom_range(0, 99) < 70) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Outputs are stable at the falling edge; a word shown with stall low is taken
    // at the next rising edge, so it is checked here against the oldest prediction.
    always @(negedge clk) begin
        pixel_word_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word status=%0d rgb=%02h%02h%02h",
                                          status, red_out, green_out, blue_out));
            end else begin
                want = pending_words.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (red_out !== want.red)
                    report_mismatch($sformatf("red %02h, expected %02h", red_out, want.red));
                if (green_out !== want.green)
                    report_mismatch($sformatf("green %02h, expected %02h", green_out,
                                              want.green));
                if (blue_out !== want.blue)
                    report_mismatch($sformatf("blue %02h, expected %02h", blue_out, want.blue));
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bilinear_image_sampler_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_size_sweep();
        test_full_image();
        test_output_holdoff();
        test_drain_pause();
        wait_drained();
        if (error_count == 0)
            $display("bilinear_image_sampler_top_tb: PASS");
        else
            $display("bilinear_image_sampler_top_tb: FAIL");
        $finish;
    end
endmodule
